FILE: sv/mie_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Modular inverse package
// Shared widths and the modulus reset value for the extended Euclidean inverse block.
// ----------------------------------------------------------------------------
package mie_pkg;

    localparam int MIE_WIDTH  = 32;   // internal datapath width
    localparam int MIE_DATA_W = 32;   // port field width

    localparam logic [MIE_DATA_W-1:0] MIE_MOD_RESET = MIE_DATA_W'(1);

endpackage
`default_nettype wire

FILE: sv/modular_inverse_ext_euclid_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Modular inverse, extended Euclidean
// Computes the Bezout coefficient of i_value modulo the configured modulus,
// reduced into 0..modulus-1, with one shared shift/subtract/add unit.
// ----------------------------------------------------------------------------
// After its last Euclid step a word goes through the closing check and the
// load of the output register. In each Euclid step the quotient is found by
// aligning the divisor with left shifts and then subtracting back down one
// bit per cycle, and the coefficient is updated in the same pass. o_stall is
// high from acceptance until the result is loaded into the output register;
// a result waiting there does not block the next word, but the load of the
// next result waits while it is held. The modulus is written through the cfg
// channel, which is always ready, and must only change while the block is
// idle.
// ----------------------------------------------------------------------------
module modular_inverse_ext_euclid_top #(
    parameter int WIDTH = mie_pkg::MIE_WIDTH
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [mie_pkg::MIE_DATA_W-1:0]  i_modulus,
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic [mie_pkg::MIE_DATA_W-1:0]  i_value,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic [mie_pkg::MIE_DATA_W-1:0]       o_inverse_value
);
    import mie_pkg::*;

    localparam int MAXW  = (WIDTH > MIE_DATA_W) ? WIDTH : MIE_DATA_W;
    localparam int CNT_W = $clog2(WIDTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_ALIGN,
        S_SUB,
        S_FINAL
    } t_state;

    t_state                  r_state;
    logic [MIE_DATA_W-1:0]   r_modulus;
    logic [WIDTH-1:0]        r_rprev, r_rcur, r_sprev, r_scur;
    logic [WIDTH-1:0]        r_d, r_sd;
    logic [CNT_W-1:0]        r_cnt;
    logic                    r_odd;
    logic                    r_out_valid;
    logic [MIE_DATA_W-1:0]   r_out_data;

    logic [MAXW-1:0]         value_ext, mod_ext, res_ext;
    logic [WIDTH-1:0]        value_w, mod_w;
    logic [WIDTH:0]          d_dbl;
    logic                    d_fits;
    logic [WIDTH-1:0]        n_rem, n_acc;
    logic [WIDTH-1:0]        red0, red;
    logic                    out_free;

    assign value_ext = MAXW'(i_value);
    assign mod_ext   = MAXW'(r_modulus);
    assign value_w   = value_ext[WIDTH-1:0];
    assign mod_w     = mod_ext[WIDTH-1:0];

    // shared unit: aligned divisor compare, remainder subtract, coefficient add
    assign d_dbl  = {r_d, 1'b0};
    assign d_fits = (r_d <= r_rprev);
    assign n_rem  = d_fits ? (r_rprev - r_d) : r_rprev;
    assign n_acc  = d_fits ? (r_sprev + r_sd) : r_sprev;

    // final reduction into 0..m-1 and sign fix
    assign red0 = (r_sprev >= mod_w) ? (r_sprev - mod_w) : r_sprev;
    always_comb begin
        if (mod_w == '0) begin
            red = '0;
        end else if (r_odd && (red0 != '0)) begin
            red = mod_w - red0;
        end else begin
            red = red0;
        end
    end
    assign res_ext = MAXW'(red);

    assign out_free        = !r_out_valid || !i_stall;
    assign o_stall         = (r_state != S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_valid         = r_out_valid;
    assign o_inverse_value = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_modulus   <= MIE_MOD_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_modulus <= i_modulus;
            end
            if (r_out_valid && !i_stall && (r_state != S_FINAL)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_rprev <= value_w;
                        r_rcur  <= mod_w;
                        r_sprev <= WIDTH'(1);
                        r_scur  <= '0;
                        r_odd   <= 1'b0;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_d   <= r_rcur;
                    r_sd  <= r_scur;
                    r_cnt <= '0;
                    if (r_rcur == '0) begin
                        r_state <= S_FINAL;
                    end else begin
                        r_state <= S_ALIGN;
                    end
                end
                S_ALIGN: begin
                    if (d_dbl <= {1'b0, r_rprev}) begin
                        r_d   <= d_dbl[WIDTH-1:0];
                        r_sd  <= {r_sd[WIDTH-2:0], 1'b0};
                        r_cnt <= r_cnt + CNT_W'(1);
                    end else begin
                        r_state <= S_SUB;
                    end
                end
                S_SUB: begin
                    if (r_cnt == '0) begin
                        r_rprev <= r_rcur;
                        r_rcur  <= n_rem;
                        r_sprev <= r_scur;
                        r_scur  <= n_acc;
                        r_odd   <= !r_odd;
                        r_state <= S_CHECK;
                    end else begin
                        r_rprev <= n_rem;
                        r_sprev <= n_acc;
                        r_d     <= {1'b0, r_d[WIDTH-1:1]};
                        r_sd    <= {1'b0, r_sd[WIDTH-1:1]};
                        r_cnt   <= r_cnt - CNT_W'(1);
                    end
                end
                S_FINAL: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= res_ext[MIE_DATA_W-1:0];
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire
